FILE: sv/text_console_cursor_engine_assert.svh
// Assertion macros shared by the text console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCCE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

FILE: sv/tcce_pkg.sv
// Types and constants of the text console cursor engine.
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int FUNC_W = 3;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 11;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [LIN_W-1:0]  lin_t;

    localparam func_t F_PRINT = 3'd0;
    localparam func_t F_CLEAR = 3'd1;
    localparam func_t F_LEFT  = 3'd2;
    localparam func_t F_RIGHT = 3'd3;
    localparam func_t F_UP    = 3'd4;
    localparam func_t F_DOWN  = 3'd5;
    localparam func_t F_SET   = 3'd6;
    localparam func_t F_WRITE = 3'd7;

    localparam char_t CH_BLANK     = 8'h20;
    localparam char_t CH_NEWLINE   = 8'h0A;
    localparam char_t CH_BACKSPACE = 8'h08;

endpackage

FILE: sv/tcce_if.sv
// Request and response channel interfaces of the text console cursor engine.
interface tcce_req_if;
    import tcce_pkg::*;
    logic  valid;
    logic  ready;
    func_t func;
    char_t char_code;
    col_t  pos_x;
    row_t  pos_y;

    modport source (output valid, func, char_code, pos_x, pos_y, input ready);
    modport sink   (input valid, func, char_code, pos_x, pos_y, output ready);
endinterface

interface tcce_rsp_if;
    import tcce_pkg::*;
    logic  valid;
    logic  ready;
    col_t  cursor_col;
    row_t  cursor_row;
    lin_t  cursor_linear;
    char_t cell_char;

    modport source (output valid, cursor_col, cursor_row, cursor_linear, cell_char,
                    input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_linear, cell_char,
                    output ready);
endinterface

FILE: sv/tcce_ram.sv
// Generic simple dual-port RAM with registered read.
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: sv/text_console_cursor_engine.sv
// Top level of the text console cursor engine: sequencer, cursor and screen store.
`include "text_console_cursor_engine_assert.svh"

// The block keeps a COLUMNS x ROWS screen of character bytes in one RAM with
// a registered read, plus a cursor, and answers every request with exactly one
// response carrying the cursor, its linear position and the byte at the
// queried cell. One request is handled at a time: cmd.ready is high only while
// the sequencer is idle. An ordinary request (print, cursor moves, set, write
// cell) passes through the four steps decode, store write, query read and
// response load; the last three share the single row*COLUMNS+column address
// unit. A clear replaces the store write with a walk over the store, one cell
// per cycle. A scroll (leaving the last row by print, newline or move right)
// copies every row up one line and blanks the last line, one cell per cycle
// through the one RAM port pair. After reset the same one-cell-per-cycle pass
// fills the store with spaces, and cmd.ready stays low until it is done. The
// response sits in an output register, so the next request is taken while it
// waits.
module text_console_cursor_engine (
    input logic        clk,
    input logic        rst_n,
    tcce_req_if.sink   cmd,
    tcce_rsp_if.source rsp
);
    import tcce_pkg::*;

    localparam int SUM_W = ADDR_W + 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_SCR  = 3'd4;
    localparam logic [2:0] S_QRY  = 3'd5;
    localparam logic [2:0] S_RSP  = 3'd6;

    localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_END     = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] CNT_SRC_END = CNT_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0] CNT_LROW    = CNT_W'((ROWS - 1) * COLUMNS);
    localparam col_t             COL_LAST    = COL_W'(COLUMNS - 1);
    localparam row_t             ROW_LAST    = ROW_W'(ROWS - 1);

    // sequencer
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             clr_rsp_reg, clr_rsp_next;

    // latched request
    func_t func_reg;
    char_t char_reg;
    col_t  px_reg;
    row_t  py_reg;
    logic  inside_reg;

    // cursor
    col_t cur_col_reg, cur_col_next;
    row_t cur_row_reg, cur_row_next;

    // pending single-cell write and scroll flag
    logic  wr_en_reg, wr_en_next;
    col_t  wr_col_reg, wr_col_next;
    row_t  wr_row_reg, wr_row_next;
    char_t wr_data_reg, wr_data_next;
    logic  scroll_reg, scroll_next;

    // response register
    logic  out_valid_reg, out_valid_next;
    col_t  out_col_reg;
    row_t  out_row_reg;
    lin_t  out_lin_reg;
    char_t out_char_reg;
    logic  out_load;

    // shared address unit
    row_t             unit_row;
    col_t             unit_col;
    logic [SUM_W-1:0] unit_sum;

    // RAM ports
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    char_t             ram_wdata, ram_rdata;

    // scroll pointers
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W:0]   cnt_src;

    // cursor helpers
    logic at_right, at_last, at_top_left;
    col_t back_col;
    row_t back_row;

    assign cmd.ready = (state_reg == S_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_col    = out_col_reg;
    assign rsp.cursor_row    = out_row_reg;
    assign rsp.cursor_linear = out_lin_reg;
    assign rsp.cell_char     = out_char_reg;

    assign at_right    = (cur_col_reg == COL_LAST);
    assign at_last     = (cur_row_reg == ROW_LAST);
    assign at_top_left = (cur_col_reg == '0) && (cur_row_reg == '0);

    // Step back one cell; from column 0 wrap to the end of the row above.
    always_comb
    begin
        if (cur_col_reg != '0)
        begin
            back_col = cur_col_reg - 1'b1;
            back_row = cur_row_reg;
        end
        else
        begin
            back_col = COL_LAST;
            back_row = cur_row_reg - 1'b1;
        end
    end

    // Address unit: row * COLUMNS + column, operands picked by the step.
    always_comb
    begin
        unique case (state_reg)
            S_WR:
            begin
                unit_row = wr_row_reg;
                unit_col = wr_col_reg;
            end
            S_QRY:
            begin
                unit_row = py_reg;
                unit_col = px_reg;
            end
            default:
            begin
                unit_row = cur_row_reg;
                unit_col = cur_col_reg;
            end
        endcase
    end

    assign unit_sum = SUM_W'(unit_row) * SUM_W'(COLUMNS) + SUM_W'(unit_col);

    assign cnt_m1  = cnt_reg - 1'b1;
    assign cnt_src = (CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(COLUMNS);

    // RAM port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[ADDR_W-1:0];
        ram_wdata = CH_BLANK;
        ram_re    = 1'b0;
        ram_raddr = unit_sum[ADDR_W-1:0];
        unique case (state_reg)
            S_CLR:
            begin
                ram_we = 1'b1;
            end
            S_WR:
            begin
                ram_we    = wr_en_reg;
                ram_waddr = unit_sum[ADDR_W-1:0];
                ram_wdata = wr_data_reg;
            end
            S_SCR:
            begin
                // read one row down, write the cell read a cycle ago
                ram_re    = (cnt_reg < CNT_SRC_END);
                ram_raddr = cnt_src[ADDR_W-1:0];
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_m1[ADDR_W-1:0];
                ram_wdata = (cnt_m1 >= CNT_LROW) ? CH_BLANK : ram_rdata;
            end
            S_QRY:
            begin
                ram_re = inside_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcce_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_load = (state_reg == S_RSP) && (!out_valid_reg || rsp.ready);

    // Sequencer and command decode.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        clr_rsp_next = clr_rsp_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        wr_en_next   = wr_en_reg;
        wr_col_next  = wr_col_reg;
        wr_row_next  = wr_row_reg;
        wr_data_next = wr_data_reg;
        scroll_next  = scroll_reg;

        unique case (state_reg)
            S_CLR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = clr_rsp_reg ? S_QRY : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next   = S_WR;
                wr_en_next   = 1'b0;
                wr_col_next  = cur_col_reg;
                wr_row_next  = cur_row_reg;
                wr_data_next = char_reg;
                scroll_next  = 1'b0;
                unique case (func_reg)
                    F_PRINT:
                    begin
                        priority if (char_reg == CH_NEWLINE)
                        begin
                            cur_col_next = '0;
                            if (at_last)
                                scroll_next = 1'b1;
                            else
                                cur_row_next = cur_row_reg + 1'b1;
                        end
                        else if (char_reg == CH_BACKSPACE)
                        begin
                            // blank the cell stepped back onto
                            if (!at_top_left)
                            begin
                                cur_col_next = back_col;
                                cur_row_next = back_row;
                                wr_en_next   = 1'b1;
                                wr_col_next  = back_col;
                                wr_row_next  = back_row;
                                wr_data_next = CH_BLANK;
                            end
                        end
                        else
                        begin
                            wr_en_next = 1'b1;
                            if (!at_right)
                                cur_col_next = cur_col_reg + 1'b1;
                            else
                            begin
                                cur_col_next = '0;
                                if (at_last)
                                    scroll_next = 1'b1;
                                else
                                    cur_row_next = cur_row_reg + 1'b1;
                            end
                        end
                    end
                    F_CLEAR:
                    begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        cnt_next     = '0;
                        clr_rsp_next = 1'b1;
                        state_next   = S_CLR;
                    end
                    F_LEFT:
                    begin
                        if (!at_top_left)
                        begin
                            cur_col_next = back_col;
                            cur_row_next = back_row;
                        end
                    end
                    F_RIGHT:
                    begin
                        if (!at_right)
                            cur_col_next = cur_col_reg + 1'b1;
                        else
                        begin
                            cur_col_next = '0;
                            if (at_last)
                                scroll_next = 1'b1;
                            else
                                cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                    F_UP:
                    begin
                        if (cur_row_reg != '0)
                            cur_row_next = cur_row_reg - 1'b1;
                    end
                    F_DOWN:
                    begin
                        if (!at_last)
                            cur_row_next = cur_row_reg + 1'b1;
                    end
                    F_SET:
                    begin
                        // saturate each coordinate to the screen edge
                        cur_col_next = (px_reg > COL_LAST) ? COL_LAST : px_reg;
                        cur_row_next = (py_reg > ROW_LAST) ? ROW_LAST : py_reg;
                    end
                    F_WRITE:
                    begin
                        wr_en_next  = inside_reg;
                        wr_col_next = px_reg;
                        wr_row_next = py_reg;
                    end
                    default:
                    begin
                        wr_en_next = 1'b0;
                    end
                endcase
            end
            S_WR:
            begin
                cnt_next   = '0;
                state_next = scroll_reg ? S_SCR : S_QRY;
            end
            S_SCR:
            begin
                if (cnt_reg == CNT_END)
                    state_next = S_QRY;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_QRY:
            begin
                state_next = S_RSP;
            end
            S_RSP:
            begin
                clr_rsp_next = 1'b0;
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            clr_rsp_reg   <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            wr_en_reg     <= 1'b0;
            scroll_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_rsp_reg   <= clr_rsp_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            wr_en_reg     <= wr_en_next;
            scroll_reg    <= scroll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold the request, the pending write and the response.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            func_reg   <= cmd.func;
            char_reg   <= cmd.char_code;
            px_reg     <= cmd.pos_x;
            py_reg     <= cmd.pos_y;
            inside_reg <= (cmd.pos_x < COL_W'(COLUMNS)) && (cmd.pos_y < ROW_W'(ROWS));
        end
        wr_col_reg  <= wr_col_next;
        wr_row_reg  <= wr_row_next;
        wr_data_reg <= wr_data_next;
        if (out_load)
        begin
            out_col_reg  <= cur_col_reg;
            out_row_reg  <= cur_row_reg;
            out_lin_reg  <= unit_sum[LIN_W-1:0];
            out_char_reg <= inside_reg ? ram_rdata : '0;
        end
    end

    `TCCE_ASSERT_NEXT(a_accept_to_exec, cmd.valid && cmd.ready, state_reg == S_EXEC)
    `TCCE_ASSERT_NOW(a_cursor_in_screen, 1'b1, (cur_col_reg <= COL_LAST) && (cur_row_reg <= ROW_LAST))
    `TCCE_ASSERT_NEXT(a_rsp_loaded, (state_reg == S_RSP) && !out_valid_reg, out_valid_reg && (state_reg == S_IDLE))

endmodule
